@@ hw/rtl/rcsr_pkg.sv @@
// Shared types, addresses and helpers for the RV64 CSR file.
`timescale 1ns / 1ps

package rcsr_pkg;

  localparam int XLEN        = 64;
  localparam int CSR_ENTRIES = 4096;
  localparam int ADDR_W      = $clog2(CSR_ENTRIES);
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  // Addresses served by dedicated registers or special write rules.
  localparam logic [ADDR_W-1:0] A_SSTATUS = 12'h100;
  localparam logic [ADDR_W-1:0] A_SIE     = 12'h104;
  localparam logic [ADDR_W-1:0] A_SIP     = 12'h144;
  localparam logic [ADDR_W-1:0] A_SATP    = 12'h180;
  localparam logic [ADDR_W-1:0] A_MSTATUS = 12'h300;
  localparam logic [ADDR_W-1:0] A_MISA    = 12'h301;
  localparam logic [ADDR_W-1:0] A_MIDELEG = 12'h303;
  localparam logic [ADDR_W-1:0] A_MIE     = 12'h304;
  localparam logic [ADDR_W-1:0] A_MIP     = 12'h344;

  // Addresses that are not implemented for reads.
  localparam logic [ADDR_W-1:0] A_UNIMP0 = 12'h14d;
  localparam logic [ADDR_W-1:0] A_UNIMP1 = 12'h30c;
  localparam logic [ADDR_W-1:0] A_UNIMP2 = 12'hda0;
  localparam logic [ADDR_W-1:0] A_UNIMP3 = 12'h321;
  localparam logic [ADDR_W-1:0] A_UNIMP4 = 12'hfb0;

  // Write-ignored ranges: upper pmp entries and hpm counters with their high halves.
  localparam logic [ADDR_W-1:0] A_PMPADDR_HI_LO = 12'h3c0;
  localparam logic [ADDR_W-1:0] A_PMPADDR_HI_HI = 12'h3ef;
  localparam logic [ADDR_W-1:0] A_PMPCFG_HI_LO  = 12'h3a4;
  localparam logic [ADDR_W-1:0] A_PMPCFG_HI_HI  = 12'h3af;
  localparam logic [ADDR_W-1:0] A_HPM_LO        = 12'hb03;
  localparam logic [ADDR_W-1:0] A_HPM_HI        = 12'hb1f;
  localparam logic [ADDR_W-1:0] A_HPMH_LO       = 12'hb83;
  localparam logic [ADDR_W-1:0] A_HPMH_HI       = 12'hb9f;

  localparam logic [1:0] READ_ONLY_SPACE = 2'b11;

  localparam int          SATP_MODE_LSB = 60;
  localparam logic [3:0]  SATP_BARE     = 4'h0;
  localparam logic [3:0]  SATP_SV39     = 4'h8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MSTATUS_WMASK = 2'd0,
    CFG_SSTATUS_WMASK = 2'd1,
    CFG_SSTATUS_RMASK = 2'd2,
    CFG_PENDING_WMASK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [XLEN-1:0] mst_wr_mask;
    logic [XLEN-1:0] sst_wr_mask;
    logic [XLEN-1:0] sst_rd_mask;
    logic [XLEN-1:0] pending_wmask;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_RD_FAIL,
    OP_RD_MEM,
    OP_RD_SSTATUS,
    OP_RD_SIE,
    OP_RD_SIP,
    OP_RD_MSTATUS,
    OP_RD_MIDELEG,
    OP_RD_MIE,
    OP_RD_MIP,
    OP_WR_NONE,
    OP_WR_MEM,
    OP_WR_MSTATUS,
    OP_WR_SSTATUS,
    OP_WR_MIP,
    OP_WR_SIE,
    OP_WR_SIP,
    OP_WR_MIDELEG,
    OP_WR_MIE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] addr;
    logic [XLEN-1:0]   data;
  } entry_t;

  function automatic logic [XLEN-1:0] merge_bits(input logic [XLEN-1:0] old_val,
                                                 input logic [XLEN-1:0] new_val,
                                                 input logic [XLEN-1:0] mask);
    merge_bits = (old_val & ~mask) | (new_val & mask);
  endfunction

endpackage

@@ hw/rtl/rcsr_req_if.sv @@
// Request channel interface of the CSR file.
`timescale 1ns / 1ps

interface rcsr_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [rcsr_pkg::ADDR_W-1:0]  csr_addr;
  logic [1:0]                   priv_mode;
  logic [rcsr_pkg::XLEN-1:0]    write_data;

  modport source (output valid, req_type, csr_addr, priv_mode, write_data, input ready);
  modport sink   (input valid, req_type, csr_addr, priv_mode, write_data, output ready);
endinterface

@@ hw/rtl/rcsr_rsp_if.sv @@
// Response channel interface of the CSR file.
`timescale 1ns / 1ps

interface rcsr_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rcsr_pkg::XLEN-1:0] read_data;
  logic                      access_ok;

  modport source (output valid, read_data, access_ok, input ready);
  modport sink   (input valid, read_data, access_ok, output ready);
endinterface

@@ hw/rtl/rcsr_front.sv @@
// Front end: accepts requests and classifies them into queue entries.
`timescale 1ns / 1ps

module rcsr_front (
  rcsr_req_if.sink         in_req,
  input  logic             clearing,
  input  logic             q_full,
  output logic             push,
  output rcsr_pkg::entry_t push_entry
);

  logic [rcsr_pkg::ADDR_W-1:0] addr;
  logic                        rd_denied;
  logic                        wr_ignored;
  logic [3:0]                  xlat_mode;

  assign in_req.ready = !clearing && !q_full;
  assign push         = in_req.valid && in_req.ready;
  assign addr         = in_req.csr_addr;
  assign xlat_mode    = in_req.write_data[rcsr_pkg::SATP_MODE_LSB +: 4];

  always_comb begin
    rd_denied = (addr[9:8] > in_req.priv_mode) ||
                (addr inside {rcsr_pkg::A_UNIMP0, rcsr_pkg::A_UNIMP1, rcsr_pkg::A_UNIMP2,
                              rcsr_pkg::A_UNIMP3, rcsr_pkg::A_UNIMP4});
    wr_ignored = (addr[11:10] == rcsr_pkg::READ_ONLY_SPACE) ||
                 (addr == rcsr_pkg::A_MISA) ||
                 (addr inside {[rcsr_pkg::A_PMPADDR_HI_LO:rcsr_pkg::A_PMPADDR_HI_HI],
                               [rcsr_pkg::A_PMPCFG_HI_LO:rcsr_pkg::A_PMPCFG_HI_HI],
                               [rcsr_pkg::A_HPM_LO:rcsr_pkg::A_HPM_HI],
                               [rcsr_pkg::A_HPMH_LO:rcsr_pkg::A_HPMH_HI]});

    push_entry.addr = addr;
    push_entry.data = in_req.write_data;
    push_entry.op   = rcsr_pkg::OP_RD_MEM;

    if (!in_req.req_type) begin
      if (rd_denied) begin
        push_entry.op = rcsr_pkg::OP_RD_FAIL;
      end else begin
        case (addr)
          rcsr_pkg::A_SSTATUS: push_entry.op = rcsr_pkg::OP_RD_SSTATUS;
          rcsr_pkg::A_SIE:     push_entry.op = rcsr_pkg::OP_RD_SIE;
          rcsr_pkg::A_SIP:     push_entry.op = rcsr_pkg::OP_RD_SIP;
          rcsr_pkg::A_MSTATUS: push_entry.op = rcsr_pkg::OP_RD_MSTATUS;
          rcsr_pkg::A_MIDELEG: push_entry.op = rcsr_pkg::OP_RD_MIDELEG;
          rcsr_pkg::A_MIE:     push_entry.op = rcsr_pkg::OP_RD_MIE;
          rcsr_pkg::A_MIP:     push_entry.op = rcsr_pkg::OP_RD_MIP;
          default:             push_entry.op = rcsr_pkg::OP_RD_MEM;
        endcase
      end
    end else if (wr_ignored) begin
      push_entry.op = rcsr_pkg::OP_WR_NONE;
    end else begin
      case (addr)
        rcsr_pkg::A_MSTATUS: push_entry.op = rcsr_pkg::OP_WR_MSTATUS;
        rcsr_pkg::A_SSTATUS: push_entry.op = rcsr_pkg::OP_WR_SSTATUS;
        rcsr_pkg::A_MIP:     push_entry.op = rcsr_pkg::OP_WR_MIP;
        rcsr_pkg::A_SIE:     push_entry.op = rcsr_pkg::OP_WR_SIE;
        rcsr_pkg::A_SIP:     push_entry.op = rcsr_pkg::OP_WR_SIP;
        rcsr_pkg::A_MIDELEG: push_entry.op = rcsr_pkg::OP_WR_MIDELEG;
        rcsr_pkg::A_MIE:     push_entry.op = rcsr_pkg::OP_WR_MIE;
        rcsr_pkg::A_SATP: begin
          push_entry.op = rcsr_pkg::OP_WR_MEM;
          // Unsupported translation modes fall back to a cleared mode field.
          if (xlat_mode != rcsr_pkg::SATP_BARE && xlat_mode != rcsr_pkg::SATP_SV39) begin
            push_entry.data[rcsr_pkg::SATP_MODE_LSB +: 4] = rcsr_pkg::SATP_BARE;
          end
        end
        default: push_entry.op = rcsr_pkg::OP_WR_MEM;
      endcase
    end
  end

endmodule

@@ hw/rtl/rcsr_fifo.sv @@
// Short queue of classified requests between front and back end.
`timescale 1ns / 1ps

module rcsr_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rcsr_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output rcsr_pkg::entry_t head_entry
);

  localparam int PTR_W = $clog2(rcsr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rcsr_pkg::QUEUE_DEPTH + 1);

  rcsr_pkg::entry_t   entries_r [rcsr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full       = (count_r == CNT_W'(rcsr_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(rcsr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(rcsr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("request popped from an empty queue");

endmodule

@@ hw/rtl/rcsr_back.sv @@
// Back end: register storage, clearing pass, execution and response register.
`timescale 1ns / 1ps

module rcsr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rcsr_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  rcsr_pkg::entry_t  q_entry,
  output logic              pop,
  output logic              clearing,
  rcsr_rsp_if.source        out_rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT
  } state_t;

  localparam int AW = rcsr_pkg::ADDR_W;
  localparam int XW = rcsr_pkg::XLEN;

  logic [XW-1:0] mem [rcsr_pkg::CSR_ENTRIES];

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [XW-1:0] rd_data_r;

  // Registers that feed masked views or masked writes live in flip-flops.
  logic [XW-1:0] mstatus_r, mstatus_nxt;
  logic [XW-1:0] mie_r, mie_nxt;
  logic [XW-1:0] mip_r, mip_nxt;
  logic [XW-1:0] mideleg_r, mideleg_nxt;

  logic          out_valid_r;
  logic [XW-1:0] out_data_r;
  logic          out_ok_r;

  logic          out_free;
  logic          res_now;
  logic [XW-1:0] res_data;
  logic          res_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [XW-1:0] mem_wdata;

  assign out_free          = !out_valid_r || out_rsp.ready;
  assign pop               = (state_r == ST_IDLE) && q_valid && out_free;
  assign clearing          = (state_r == ST_CLEAR);
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.read_data = out_data_r;
  assign out_rsp.access_ok = out_ok_r;

  always_comb begin
    state_nxt   = state_r;
    res_now     = 1'b0;
    res_data    = '0;
    res_ok      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = q_entry.addr;
    mem_wdata   = q_entry.data;
    mstatus_nxt = mstatus_r;
    mie_nxt     = mie_r;
    mip_nxt     = mip_r;
    mideleg_nxt = mideleg_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == AW'(rcsr_pkg::CSR_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          res_now = 1'b1;
          res_ok  = 1'b1;
          case (q_entry.op)
            rcsr_pkg::OP_RD_FAIL: res_ok = 1'b0;
            rcsr_pkg::OP_RD_MEM: begin
              res_now   = 1'b0;
              state_nxt = ST_RDWAIT;
            end
            rcsr_pkg::OP_RD_SSTATUS: res_data = mstatus_r & cfg.sst_rd_mask;
            rcsr_pkg::OP_RD_SIE:     res_data = mie_r & mideleg_r;
            rcsr_pkg::OP_RD_SIP:     res_data = mip_r & mideleg_r;
            rcsr_pkg::OP_RD_MSTATUS: res_data = mstatus_r;
            rcsr_pkg::OP_RD_MIDELEG: res_data = mideleg_r;
            rcsr_pkg::OP_RD_MIE:     res_data = mie_r;
            rcsr_pkg::OP_RD_MIP:     res_data = mip_r;
            rcsr_pkg::OP_WR_NONE:    res_ok = 1'b0;
            rcsr_pkg::OP_WR_MEM:     mem_we = 1'b1;
            rcsr_pkg::OP_WR_MSTATUS:
              mstatus_nxt = rcsr_pkg::merge_bits(mstatus_r, q_entry.data, cfg.mst_wr_mask);
            rcsr_pkg::OP_WR_SSTATUS:
              mstatus_nxt = rcsr_pkg::merge_bits(mstatus_r, q_entry.data, cfg.sst_wr_mask);
            rcsr_pkg::OP_WR_MIP:
              mip_nxt = rcsr_pkg::merge_bits(mip_r, q_entry.data, cfg.pending_wmask);
            rcsr_pkg::OP_WR_SIE:
              mie_nxt = rcsr_pkg::merge_bits(mie_r, q_entry.data, mideleg_r);
            rcsr_pkg::OP_WR_SIP:
              mip_nxt = rcsr_pkg::merge_bits(mip_r, q_entry.data,
                                             mideleg_r & cfg.pending_wmask);
            rcsr_pkg::OP_WR_MIDELEG: mideleg_nxt = q_entry.data;
            rcsr_pkg::OP_WR_MIE:     mie_nxt = q_entry.data;
            default:                 res_ok = 1'b0;
          endcase
        end
      end
      ST_RDWAIT: begin
        // The store data read at the pop edge is now registered.
        res_now   = 1'b1;
        res_ok    = 1'b1;
        res_data  = rd_data_r;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mstatus_r   <= '0;
      mie_r       <= '0;
      mip_r       <= '0;
      mideleg_r   <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstatus_r   <= mstatus_nxt;
      mie_r       <= mie_nxt;
      mip_r       <= mip_nxt;
      mideleg_r   <= mideleg_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (res_now) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_data;
        out_ok_r    <= res_ok;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[q_entry.addr];
  end

  a_rdwait_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDWAIT |-> !out_valid_r)
    else $error("response register busy while a store read completes");

  a_rdwait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RDWAIT |=> out_valid_r)
    else $error("store read produced no response");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop && !out_valid_r)
    else $error("request executed during the clearing pass");

endmodule

@@ hw/rtl/riscv_csr_file_top.sv @@
// Top level of the RV64 CSR file: configuration registers and the front/queue/back.
// Path: an accepted request is registered in the queue, then executed when popped and its
// response registered; reads of CSRs held in the store also pass through ST_RDWAIT.
// Throughput: one request per cycle while out_rsp.ready is high; a store read holds the
// back end in ST_RDWAIT. Reset: a clearing pass zeroes all 4096 store entries;
// in_req.ready stays low until it ends, while configuration writes are taken at once.
`timescale 1ns / 1ps

module riscv_csr_file_top (
  input  logic                             clk,
  input  logic                             rst_n,
  rcsr_req_if.sink                         in_req,
  rcsr_rsp_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [rcsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcsr_pkg::XLEN-1:0]        cfg_wdata
);

  rcsr_pkg::cfg_t   cfg_r;
  logic             clearing;
  logic             q_full;
  logic             q_valid;
  logic             push;
  logic             pop;
  rcsr_pkg::entry_t push_entry;
  rcsr_pkg::entry_t head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (rcsr_pkg::cfg_idx_t'(cfg_index))
        rcsr_pkg::CFG_MSTATUS_WMASK: cfg_r.mst_wr_mask   <= cfg_wdata;
        rcsr_pkg::CFG_SSTATUS_WMASK: cfg_r.sst_wr_mask   <= cfg_wdata;
        rcsr_pkg::CFG_SSTATUS_RMASK: cfg_r.sst_rd_mask   <= cfg_wdata;
        rcsr_pkg::CFG_PENDING_WMASK: cfg_r.pending_wmask <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rcsr_front u_front (
    .in_req     (in_req),
    .clearing   (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  rcsr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  rcsr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_entry  (head_entry),
    .pop      (pop),
    .clearing (clearing),
    .out_rsp  (out_rsp)
  );

endmodule
